// ===== rtl/prls_pkg.sv =====
// shared types and constants of the priority ready list scheduler
// no dependencies; used by prls_ctrl and priority_ready_list_scheduler
`timescale 1ns / 1ps

package prls_pkg;

  // fixed field widths
  localparam int ID_W      = 4;
  localparam int OP_W      = 2;
  localparam int PRIO_IN_W = 8;
  localparam int CNT_OUT_W = 5;
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SWITCH = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PREEMPT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE    = 1'b1;

  // configuration seen by the sequencer
  typedef struct packed {
    logic            preempt;
    logic [ID_W-1:0] idle;
  } cfg_t;

  // one input word
  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [ID_W-1:0]      tid;
    logic [PRIO_IN_W-1:0] prio;
    logic                 ready;
    logic                 locked;
  } cmd_t;

  // one result word
  typedef struct packed {
    logic [ID_W-1:0]      top;
    logic [ID_W-1:0]      running;
    logic [CNT_OUT_W-1:0] count;
    logic                 req;
    logic                 refused;
    logic                 full;
  } res_t;

endpackage

// ===== rtl/priority_ready_list_scheduler.sv =====
// top level of the priority ready list scheduler: configuration, handshakes
// depends on prls_pkg, prls_ram and prls_ctrl
`timescale 1ns / 1ps

// channel   handshake                 payload
// config    cfg_we_i                  cfg_idx_i, cfg_wdata_i
// input     in_valid_i / in_stall_o   op_i, thread_id_i, priority_req_i,
//                                     still_ready_i, sched_locked_i
// output    out_valid_o / out_stall_i top_thread_o, running_thread_o,
//                                     active_count_o, switch_required_o,
//                                     switch_refused_o, list_full_o
//
// one word at a time; the list lives in one ram with a single read port, and
// each scan or shift steps one entry a cycle. a remove scans the list once, an
// insert scans it and may then shift the tail, a switch removes, then inserts.
// reset empties the list at once (entry count to zero), no clearing pass.
// a new word is taken while a result waits; it finishes once the result moves.

module priority_ready_list_scheduler #(
  parameter int MAX_THREADS = 16,
  parameter int PRIO_BITS   = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [prls_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [prls_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [prls_pkg::OP_W-1:0]         op_i,
  input  logic [prls_pkg::ID_W-1:0]         thread_id_i,
  input  logic [prls_pkg::PRIO_IN_W-1:0]    priority_req_i,
  input  logic                              still_ready_i,
  input  logic                              sched_locked_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [prls_pkg::ID_W-1:0]         top_thread_o,
  output logic [prls_pkg::ID_W-1:0]         running_thread_o,
  output logic [prls_pkg::CNT_OUT_W-1:0]    active_count_o,
  output logic                              switch_required_o,
  output logic                              switch_refused_o,
  output logic                              list_full_o
);

  localparam int IW = $clog2(MAX_THREADS);
  localparam int EW = prls_pkg::ID_W + PRIO_BITS;

  logic                         preempt_q;
  logic [prls_pkg::ID_W-1:0]    idle_q;
  prls_pkg::cfg_t               cfg;
  prls_pkg::cmd_t               cmd;
  prls_pkg::res_t               res;
  prls_pkg::res_t               res_q;
  logic                         out_valid_q;
  logic                         busy;
  logic                         start;
  logic                         done;
  logic                         res_ready;
  logic                         ram_we;
  logic [IW-1:0]                ram_waddr;
  logic [EW-1:0]                ram_wdata;
  logic [IW-1:0]                ram_raddr;
  logic [EW-1:0]                ram_rdata;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preempt_q <= 1'b1;
      idle_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        prls_pkg::CFG_PREEMPT: preempt_q <= cfg_wdata_i[0];
        prls_pkg::CFG_IDLE:    idle_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg.preempt = preempt_q;
  assign cfg.idle    = idle_q;

  // input handshake
  assign in_stall_o = busy;
  assign start      = in_valid_i && !busy;
  assign cmd.op     = op_i;
  assign cmd.tid    = thread_id_i;
  assign cmd.prio   = priority_req_i;
  assign cmd.ready  = still_ready_i;
  assign cmd.locked = sched_locked_i;

  // output register takes a result once the previous word has left
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      res_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign top_thread_o      = res_q.top;
  assign running_thread_o  = res_q.running;
  assign active_count_o    = res_q.count;
  assign switch_required_o = res_q.req;
  assign switch_refused_o  = res_q.refused;
  assign list_full_o       = res_q.full;

  // list storage: {id, priority} per entry
  prls_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_THREADS)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // list sequencer
  prls_ctrl #(
    .MAX_THREADS (MAX_THREADS),
    .PRIO_BITS   (PRIO_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .start_i     (start),
    .cmd_i       (cmd),
    .busy_o      (busy),
    .res_ready_i (res_ready),
    .done_o      (done),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

endmodule

// ===== rtl/prls_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module prls_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/prls_ctrl.sv =====
// sequencer of the ready list: scans, shifts and writes the list ram
// depends on prls_pkg; drives one prls_ram instance in the top level
`timescale 1ns / 1ps

module prls_ctrl #(
  parameter int MAX_THREADS = 16,
  parameter int PRIO_BITS   = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  prls_pkg::cfg_t                      cfg_i,
  input  logic                                start_i,
  input  prls_pkg::cmd_t                      cmd_i,
  output logic                                busy_o,
  input  logic                                res_ready_i,
  output logic                                done_o,
  output prls_pkg::res_t                      res_o,
  output logic                                ram_we_o,
  output logic [$clog2(MAX_THREADS)-1:0]      ram_waddr_o,
  output logic [prls_pkg::ID_W+PRIO_BITS-1:0] ram_wdata_o,
  output logic [$clog2(MAX_THREADS)-1:0]      ram_raddr_o,
  input  logic [prls_pkg::ID_W+PRIO_BITS-1:0] ram_rdata_i
);

  localparam int IW = $clog2(MAX_THREADS);
  localparam int CW = $clog2(MAX_THREADS + 1);
  localparam int PW = PRIO_BITS;
  localparam int DW = prls_pkg::ID_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_REM   = 3'd1;
  localparam logic [2:0] ST_INS   = 3'd2;
  localparam logic [2:0] ST_SHIFT = 3'd3;
  localparam logic [2:0] ST_PUT   = 3'd4;
  localparam logic [2:0] ST_SWEND = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic          ready_q, ready_d;
  logic          sw_q, sw_d;
  logic [DW-1:0] key_id_q, key_id_d;
  logic [PW-1:0] key_prio_q, key_prio_d;
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] proc_idx_q, proc_idx_d;
  logic          pend_q, pend_d;
  logic          hit_q, hit_d;
  logic          pos_found_q, pos_found_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] count_q, count_d;
  logic [DW-1:0] head_id_q, head_id_d;
  logic [PW-1:0] head_prio_q, head_prio_d;
  logic [DW-1:0] run_id_q, run_id_d;
  logic [PW-1:0] run_prio_q, run_prio_d;
  logic          refused_q, refused_d;
  logic          full_q, full_d;

  logic [15:0]   prio_wide;
  logic [PW-1:0] prio_in;
  logic [DW-1:0] rd_id;
  logic [PW-1:0] rd_prio;
  logic [CW-1:0] proc_prev;
  logic [CW-1:0] rd_prev;
  logic          scan_end;
  logic [2:0]    after_ins;
  logic [7:0]    cnt_wide;

  // request priority cut or widened to the list width
  assign prio_wide = 16'(cmd_i.prio);
  assign prio_in   = prio_wide[PW-1:0];

  // fields of the entry just read
  assign rd_id   = ram_rdata_i[PW +: DW];
  assign rd_prio = ram_rdata_i[PW-1:0];

  assign proc_prev = proc_idx_q - CW'(1);
  assign rd_prev   = rd_idx_q - CW'(1);
  assign scan_end  = !pend_q && (rd_idx_q >= count_q);
  assign after_ins = sw_q ? ST_SWEND : ST_DONE;

  // sequencer
  always_comb begin
    state_d     = state_q;
    ready_d     = ready_q;
    sw_d        = sw_q;
    key_id_d    = key_id_q;
    key_prio_d  = key_prio_q;
    rd_idx_d    = rd_idx_q;
    proc_idx_d  = proc_idx_q;
    pend_d      = pend_q;
    hit_d       = hit_q;
    pos_found_d = pos_found_q;
    pos_d       = pos_q;
    count_d     = count_q;
    head_id_d   = head_id_q;
    head_prio_d = head_prio_q;
    run_id_d    = run_id_q;
    run_prio_d  = run_prio_q;
    refused_d   = refused_q;
    full_d      = full_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = '0;
    ram_raddr_o = rd_idx_q[IW-1:0];
    done_o      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          ready_d     = cmd_i.ready;
          sw_d        = 1'b0;
          refused_d   = 1'b0;
          full_d      = 1'b0;
          rd_idx_d    = '0;
          pend_d      = 1'b0;
          hit_d       = 1'b0;
          pos_found_d = 1'b0;
          pos_d       = count_q;
          key_id_d    = cmd_i.tid;
          key_prio_d  = prio_in;
          unique case (cmd_i.op)
            prls_pkg::OP_INSERT: state_d = ST_INS;
            prls_pkg::OP_REMOVE: begin
              state_d = (cmd_i.tid == cfg_i.idle) ? ST_DONE : ST_REM;
            end
            prls_pkg::OP_SWITCH: begin
              if (cmd_i.locked) begin
                refused_d = 1'b1;
                state_d   = ST_DONE;
              end else begin
                sw_d       = 1'b1;
                key_id_d   = run_id_q;
                key_prio_d = run_prio_q;
                if (run_id_q == cfg_i.idle) begin
                  state_d = cmd_i.ready ? ST_INS : ST_SWEND;
                end else begin
                  state_d = ST_REM;
                end
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end

      // locate and close the gap in one pass
      ST_REM: begin
        if (pend_q) begin
          if (hit_q) begin
            ram_we_o    = 1'b1;
            ram_waddr_o = proc_prev[IW-1:0];
            ram_wdata_o = ram_rdata_i;
            if (proc_prev == '0) begin
              head_id_d   = rd_id;
              head_prio_d = rd_prio;
            end
          end else if (rd_id == key_id_q) begin
            hit_d = 1'b1;
          end
        end
        if (rd_idx_q < count_q) begin
          proc_idx_d = rd_idx_q;
          rd_idx_d   = rd_idx_q + CW'(1);
          pend_d     = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (scan_end) begin
          if (hit_q) begin
            count_d = count_q - CW'(1);
          end
          pos_d       = hit_q ? count_q - CW'(1) : count_q;
          rd_idx_d    = '0;
          pend_d      = 1'b0;
          hit_d       = 1'b0;
          pos_found_d = 1'b0;
          if (sw_q && ready_q) begin
            state_d = ST_INS;
          end else begin
            state_d = after_ins;
          end
        end
      end

      // look for a duplicate and the insert position
      ST_INS: begin
        if (pend_q) begin
          if (rd_id == key_id_q) begin
            hit_d = 1'b1;
          end
          if (!pos_found_q && (key_prio_q > rd_prio)) begin
            pos_found_d = 1'b1;
            pos_d       = proc_idx_q;
          end
        end
        if (rd_idx_q < count_q) begin
          proc_idx_d = rd_idx_q;
          rd_idx_d   = rd_idx_q + CW'(1);
          pend_d     = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (scan_end) begin
          pend_d = 1'b0;
          if (hit_q) begin
            state_d = after_ins;
          end else if (count_q == CW'(MAX_THREADS)) begin
            full_d  = 1'b1;
            state_d = after_ins;
          end else begin
            rd_idx_d = count_q;
            state_d  = ST_SHIFT;
          end
        end
      end

      // move the tail up by one, top entry first
      ST_SHIFT: begin
        ram_raddr_o = rd_prev[IW-1:0];
        if (pend_q) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = proc_idx_q[IW-1:0];
          ram_wdata_o = ram_rdata_i;
        end
        if (rd_idx_q > pos_q) begin
          proc_idx_d = rd_idx_q;
          rd_idx_d   = rd_prev;
          pend_d     = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (!pend_q && (rd_idx_q <= pos_q)) begin
          state_d = ST_PUT;
        end
      end

      // write the new entry into the gap
      ST_PUT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = pos_q[IW-1:0];
        ram_wdata_o = {key_id_q, key_prio_q};
        if (pos_q == '0) begin
          head_id_d   = key_id_q;
          head_prio_d = key_prio_q;
        end
        count_d = count_q + CW'(1);
        if (key_id_q == run_id_q) begin
          run_prio_d = key_prio_q;
        end
        state_d = after_ins;
      end

      // head of the list, if there is one, becomes the running thread
      ST_SWEND: begin
        if (count_q != '0) begin
          run_id_d   = head_id_q;
          run_prio_d = head_prio_q;
        end
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (res_ready_i) begin
          done_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      count_q     <= '0;
      run_id_q    <= '0;
      run_prio_q  <= '0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      count_q     <= count_d;
      run_id_q    <= run_id_d;
      run_prio_q  <= run_prio_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    ready_q     <= ready_d;
    sw_q        <= sw_d;
    key_id_q    <= key_id_d;
    key_prio_q  <= key_prio_d;
    rd_idx_q    <= rd_idx_d;
    proc_idx_q  <= proc_idx_d;
    hit_q       <= hit_d;
    pos_found_q <= pos_found_d;
    pos_q       <= pos_d;
    head_id_q   <= head_id_d;
    head_prio_q <= head_prio_d;
    refused_q   <= refused_d;
    full_q      <= full_d;
  end

  // result word
  assign cnt_wide      = 8'(count_q);
  assign busy_o        = (state_q != ST_IDLE);
  assign res_o.top     = (count_q != '0) ? head_id_q : '0;
  assign res_o.running = run_id_q;
  assign res_o.count   = cnt_wide[prls_pkg::CNT_OUT_W-1:0];
  assign res_o.req     = (cfg_i.preempt || (run_id_q == cfg_i.idle)) && (count_q > CW'(1));
  assign res_o.refused = refused_q;
  assign res_o.full    = full_q;

endmodule
